FILE: sv/rix_pkg.sv
package rix_pkg;

  localparam int ATAN_LEN = 24;
  localparam int TRIG_W = 33;
  localparam int VEC_W = 60;

  // arctangent of 2^-i, 2^32 per full turn
  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [31:0] INVALID_LIMIT = -32'sd655360000;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef enum logic [3:0] {
    REG_CAM_X        = 4'd0,
    REG_CAM_Y        = 4'd1,
    REG_CAM_Z        = 4'd2,
    REG_ROLL_ANGLE   = 4'd3,
    REG_PITCH_ANGLE  = 4'd4,
    REG_YAW_ANGLE    = 4'd5,
    REG_FOCAL_LENGTH = 4'd6,
    REG_RANGE_SCALE  = 4'd7
  } rix_reg_t;

  typedef struct packed {
    logic [9:0]         column;
    logic [9:0]         row;
    logic signed [31:0] range_value;
  } rix_in_t;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic               invalid_flag;
  } rix_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

FILE: sv/rix_dly.sv
module rix_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    sr_r[0] <= din;
    for (int i = 1; i < D; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[D-1];

endmodule

FILE: sv/rix_rot.sv
module rix_rot import rix_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic        clk,
  input  logic [31:0] angle,
  output trig_t       cos_out,
  output trig_t       sin_out
);

  logic [31:0] a_sum;
  logic [31:0] a_adj;
  logic        flip;

  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [33:0] z_r [STAGES+1];
  logic               flip_r [STAGES+1];

  // fold the left half plane onto the right one, undone at the end
  always_comb begin
    a_sum = angle + QUARTER_TURN;
    flip = a_sum[31];
    a_adj = flip ? angle - HALF_TURN : angle;
  end

  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= 34'($signed(a_adj));
    flip_r[0] <= flip;
    for (int i = 0; i < STAGES; i++) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - $signed({2'b00, ATAN_TABLE[i]});
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + $signed({2'b00, ATAN_TABLE[i]});
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  assign cos_out = TRIG_W'(flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES]);
  assign sin_out = TRIG_W'(flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES]);

endmodule

FILE: sv/rix_vec.sv
module rix_vec import rix_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic signed [VEC_W-1:0] y_in,
  input  logic signed [VEC_W-1:0] x_in,
  output logic [31:0]             angle
);

  logic signed [VEC_W-1:0] x_r [STAGES+1];
  logic signed [VEC_W-1:0] y_r [STAGES+1];
  logic [31:0]             z_r [STAGES+1];
  logic                    zero_r [STAGES+1];

  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      x_r[0] <= -x_in;
      y_r[0] <= -y_in;
      z_r[0] <= HALF_TURN;
    end else begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      z_r[0] <= '0;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_TABLE[i];
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_TABLE[i];
      end
      zero_r[i+1] <= zero_r[i];
    end
  end

  assign angle = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

FILE: sv/range_image_to_xyz_core.sv
// Range pixel to world point converter.
// Input: pulse start with in_data (column, row, range); a transaction is taken
// when start is high and busy is low. busy is high only during reset and in
// the cycle after it, so one pixel can be taken in every cycle.
// Output: out_strobe is high for one cycle with out_data (x, y, z, flag). The
// receiver must take it in that cycle; there is no back pressure.
// Datapath: five CORDIC pipelines in series (roll/pitch rotation, azimuth
// vectoring, azimuth/yaw rotation, elevation vectoring, elevation rotation)
// plus the multiplier stages between them. Throughput: one pixel per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no pixel is in flight.
// Reset: synchronous, active low; clears all in-flight pixels and returns
// the registers to their reset values.
module range_image_to_xyz_core import rix_pkg::*; #(
  parameter int IMAGE_WIDTH   = 1024,
  parameter int IMAGE_HEIGHT  = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rix_in_t     in_data,
  output logic        out_strobe,
  output rix_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = CORDIC_STAGES;
  localparam int LAT = 5 * N + 16;
  localparam logic signed [21:0] W_Q8 = 22'(IMAGE_WIDTH * 128);
  localparam logic signed [21:0] H_Q8 = 22'((IMAGE_HEIGHT - 2) * 128);

  // configuration registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [15:0]        roll_r, yaw_r, range_scale_r;
  logic [14:0]        pitch_r;
  logic [23:0]        focal_r;

  logic               busy_r;
  logic [LAT-1:0]     vld_r;
  logic               acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      roll_r <= '0;
      pitch_r <= '0;
      yaw_r <= '0;
      focal_r <= 24'd743343;
      range_scale_r <= 16'd256;
      busy_r <= 1'b1;
      vld_r <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r <= {vld_r[LAT-2:0], acc};
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAM_X:        cam_x_r <= cfg_data;
          REG_CAM_Y:        cam_y_r <= cfg_data;
          REG_CAM_Z:        cam_z_r <= cfg_data;
          REG_ROLL_ANGLE:   roll_r <= cfg_data[15:0];
          REG_PITCH_ANGLE:  pitch_r <= cfg_data[14:0];
          REG_YAW_ANGLE:    yaw_r <= cfg_data[15:0];
          REG_FOCAL_LENGTH: focal_r <= cfg_data[23:0];
          REG_RANGE_SCALE:  range_scale_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;
  assign cfg_ready = 1'b1;
  assign acc = start & ~busy_r;
  assign out_strobe = vld_r[LAT-1];

  // stage 1: pixel offsets from the centre, row flipped bottom-up
  logic signed [21:0] dx_r, dy_r;
  logic signed [31:0] rv_r;
  logic               inv_r;

  always_ff @(posedge clk) begin
    dx_r <= $signed({4'b0, in_data.column, 8'b0}) - W_Q8;
    dy_r <= H_Q8 - $signed({4'b0, in_data.row, 8'b0});
    rv_r <= in_data.range_value;
    inv_r <= in_data.range_value < INVALID_LIMIT;
  end

  // range scaling, runs alongside everything else
  logic signed [48:0] sprod_r;
  logic signed [31:0] scaled_r;

  always_ff @(posedge clk) begin
    sprod_r <= rv_r * $signed({1'b0, range_scale_r});
    scaled_r <= sat32(64'(sprod_r >>> 8));
  end

  // roll and pitch trig, launched with the pixel
  trig_t cr, sr, cp, sp;
  logic [31:0] roll_in, pitch_in;
  assign roll_in = 32'd0 - {roll_r, 16'b0};
  assign pitch_in = {pitch_r[14], pitch_r, 16'b0};

  rix_rot #(.STAGES(N)) u_rot_roll (.clk(clk), .angle(roll_in), .cos_out(cr), .sin_out(sr));
  rix_rot #(.STAGES(N)) u_rot_pitch (.clk(clk), .angle(pitch_in), .cos_out(cp), .sin_out(sp));

  logic signed [21:0] dx_d, dy_d;
  rix_dly #(.W(44), .D(N)) u_dly_pix (.clk(clk), .din({dx_r, dy_r}), .dout({dx_d, dy_d}));

  // de-roll
  logic signed [54:0] pm_a_r, pm_b_r, pm_c_r, pm_d_r;
  trig_t              cp1_r, sp1_r, cp2_r, sp2_r;
  logic signed [55:0] sum_x, sum_y;
  logic signed [22:0] xr_r, yr_r, xr3_r;

  assign sum_x = 56'(pm_a_r) - 56'(pm_b_r);
  assign sum_y = 56'(pm_c_r) + 56'(pm_d_r);

  always_ff @(posedge clk) begin
    pm_a_r <= dx_d * cr;
    pm_b_r <= dy_d * sr;
    pm_c_r <= dy_d * cr;
    pm_d_r <= dx_d * sr;
    cp1_r <= cp;
    sp1_r <= sp;
    xr_r <= 23'(sum_x >>> 30);
    yr_r <= 23'(sum_y >>> 30);
    cp2_r <= cp1_r;
    sp2_r <= sp1_r;
  end

  // pitch terms of the ray
  logic signed [55:0] q_a_r, q_d_r;
  logic signed [57:0] q_b_r, q_c_r;
  logic signed [56:0] den_r, a_r;
  logic signed [52:0] yth_r;
  logic signed [24:0] hq;

  assign hq = $signed({1'b0, focal_r});

  always_ff @(posedge clk) begin
    q_a_r <= yr_r * sp2_r;
    q_b_r <= hq * cp2_r;
    q_c_r <= hq * sp2_r;
    q_d_r <= yr_r * cp2_r;
    xr3_r <= xr_r;
    den_r <= 57'(q_a_r + q_b_r);
    a_r <= 57'(q_c_r - q_d_r);
    yth_r <= {xr3_r, 30'b0};
  end

  // azimuth
  logic [31:0] theta, yaw_in;
  rix_vec #(.STAGES(N)) u_vec_theta (
    .clk(clk), .y_in(VEC_W'(yth_r)), .x_in(VEC_W'(den_r)), .angle(theta)
  );

  assign yaw_in = {yaw_r, 16'b0} - theta;

  trig_t ct, st, cy, sy;
  rix_rot #(.STAGES(N)) u_rot_theta (.clk(clk), .angle(theta), .cos_out(ct), .sin_out(st));
  rix_rot #(.STAGES(N)) u_rot_yaw (.clk(clk), .angle(yaw_in), .cos_out(cy), .sin_out(sy));

  logic signed [56:0] a_d, den_d;
  rix_dly #(.W(114), .D(2 * N + 2)) u_dly_den (
    .clk(clk), .din({a_r, den_r}), .dout({a_d, den_d})
  );

  // elevation numerator: a * cos(theta) split into two narrow products
  logic signed [26:0] a_hi;
  logic signed [30:0] a_lo;
  logic signed [59:0] mh_r;
  logic signed [63:0] ml_r;
  logic signed [56:0] den_m1_r, den_m2_r;
  logic signed [57:0] num_r, numn_r, denn_r;
  trig_t              cy1_r, sy1_r;

  assign a_hi = 27'(a_d >>> 30);
  assign a_lo = $signed({1'b0, a_d[29:0]});

  always_ff @(posedge clk) begin
    mh_r <= a_hi * ct;
    ml_r <= a_lo * ct;
    den_m1_r <= den_d;
    cy1_r <= cy;
    sy1_r <= sy;
    num_r <= 58'(mh_r + (ml_r >>> 30));
    den_m2_r <= den_m1_r;
    // keep the denominator non-negative for the principal arctangent
    if (den_m2_r < 0) begin
      numn_r <= -num_r;
      denn_r <= -58'(den_m2_r);
    end else begin
      numn_r <= num_r;
      denn_r <= 58'(den_m2_r);
    end
  end

  logic [31:0] gamma;
  rix_vec #(.STAGES(N)) u_vec_gamma (
    .clk(clk), .y_in(VEC_W'(numn_r)), .x_in(VEC_W'(denn_r)), .angle(gamma)
  );

  trig_t cg, sg;
  rix_rot #(.STAGES(N)) u_rot_gamma (.clk(clk), .angle(gamma), .cos_out(cg), .sin_out(sg));

  logic signed [31:0] scaled_d;
  rix_dly #(.W(32), .D(5 * N + 9)) u_dly_scl (.clk(clk), .din(scaled_r), .dout(scaled_d));

  trig_t cy_d, sy_d;
  rix_dly #(.W(2 * TRIG_W), .D(2 * N + 6)) u_dly_yaw (
    .clk(clk), .din({cy1_r, sy1_r}), .dout({cy_d, sy_d})
  );

  logic               inv_d;
  logic signed [31:0] rv_d;
  rix_dly #(.W(33), .D(5 * N + 14)) u_dly_rv (
    .clk(clk), .din({inv_r, rv_r}), .dout({inv_d, rv_d})
  );

  // projection onto the world axes
  logic signed [64:0] gp_r, zp_r;
  logic signed [32:0] ground_r, zt_r, zt3_r;
  logic signed [65:0] gx_r, gy_r;
  logic signed [63:0] xs, ys, zs;

  always_ff @(posedge clk) begin
    gp_r <= scaled_d * cg;
    zp_r <= scaled_d * sg;
    ground_r <= 33'(gp_r >>> 30);
    zt_r <= 33'(zp_r >>> 30);
    gx_r <= ground_r * cy_d;
    gy_r <= ground_r * sy_d;
    zt3_r <= zt_r;
  end

  assign xs = 64'(cam_x_r) + 64'(gx_r >>> 30);
  assign ys = 64'(cam_y_r) + 64'(gy_r >>> 30);
  assign zs = 64'(cam_z_r) - 64'(zt3_r);

  always_ff @(posedge clk) begin
    if (inv_d) begin
      out_data.x_coord <= rv_d;
      out_data.y_coord <= rv_d;
      out_data.z_coord <= rv_d;
      out_data.invalid_flag <= 1'b1;
    end else begin
      out_data.x_coord <= sat32(xs);
      out_data.y_coord <= sat32(ys);
      out_data.z_coord <= sat32(zs);
      out_data.invalid_flag <= 1'b0;
    end
  end

endmodule

FILE: sv/rix_chk.sv
module rix_chk import rix_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input rix_out_t    out_data,
  input logic        out_strobe
);

  localparam int LAT = 5 * CORDIC_STAGES + 16;

  // every result traces back to a transaction taken a fixed latency earlier
  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without matching input transaction");

  a_invalid_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.invalid_flag) |->
      (out_data.x_coord == out_data.y_coord && out_data.y_coord == out_data.z_coord))
    else $error("invalid pixel not copied to all coordinates");

  a_invalid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.invalid_flag) |-> (out_data.x_coord < INVALID_LIMIT))
    else $error("invalid flag on a valid range");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind range_image_to_xyz_core rix_chk #(.CORDIC_STAGES(CORDIC_STAGES)) u_rix_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_data(out_data),
  .out_strobe(out_strobe)
);
